// ===== design/sphdp_pkg.sv =====
`timescale 1ns / 1ps

package sphdp_pkg;

   localparam int unsigned COORD_WIDTH     = 32;
   localparam int unsigned CSR_WIDTH       = 32;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned SUM_WIDTH       = 40;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RADIUS_SQ        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INV_RADIUS_SQ    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DENSITY_SCALE    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INV_REST_DENSITY = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STIFFNESS        = 3'd4;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] offset_x;
      logic signed [COORD_WIDTH-1:0] offset_y;
      logic signed [COORD_WIDTH-1:0] offset_z;
      logic                          last_pair;
   } req_word_type;

   typedef struct packed {
      logic [31:0] density;
      logic [31:0] pressure;
      logic        saturated;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_SUM,
      ST_RADIUS,
      ST_QUOT,
      ST_BASE_SQ,
      ST_BASE_CUBE,
      ST_WEIGHT,
      ST_LOAD,
      ST_WIDE,
      ST_WIDE_LAST,
      ST_WIDE_FIN,
      ST_EMIT
   } seq_state_type;

   typedef enum logic [2:0] {
      JOB_DENSITY,
      JOB_RATIO,
      JOB_T2,
      JOB_T3,
      JOB_T4,
      JOB_T7,
      JOB_PRESSURE
   } job_type;

endpackage

// ===== design/sph_density_pressure_top.sv =====
`timescale 1ns / 1ps
// Pair word: taken only in idle, each done before the next is accepted; set by one shared
// 32x32 multiplier stepping dx^2, dy^2, dz^2, r^2/h^2, base^2 and base^3.
// A last pair then runs six or seven 64x64 products (seven when the pressure product runs),
// each as four partial products plus an accumulate and a finish step on the same multiplier.
// ST_EMIT raises rsp_valid after the finish, later while an earlier word stalls; req_ready is
// high only in idle. Reset (synchronous, active high): control regs cleared, weight sum 1.0.

module sph_density_pressure_top
   import sphdp_pkg::*;
#(
   parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_word_type               req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_word_type               rsp_word,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata
);

   localparam int unsigned WF         = WEIGHT_FRAC_BITS;
   localparam int unsigned BASE_WIDTH = WF + 1;
   localparam logic [BASE_WIDTH-1:0] BASE_ONE = {1'b1, {WF{1'b0}}};
   localparam logic [SUM_WIDTH-1:0]  SUM_ONE  = SUM_WIDTH'(1) << WF;
   localparam logic [63:0]           T_ONE    = 64'h0000_0001_0000_0000;

   function automatic logic [31:0] magnitude(input logic [31:0] v);
      magnitude = v[31] ? (~v + 32'd1) : v;
   endfunction

   // configuration
   logic [31:0] radius_sq_ff, inv_radius_sq_ff, density_scale_ff, inv_rest_ff, stiffness_ff;

   // sequencer
   seq_state_type state_ff, state_in;
   job_type       job_ff, job_in;
   logic [1:0]    phase_ff, phase_in;

   // datapath
   logic [31:0]           mag_x_ff, mag_x_in, mag_y_ff, mag_y_in, mag_z_ff, mag_z_in;
   logic                  last_ff, last_in;
   logic [31:0]           mul_a, mul_b;
   logic [63:0]           prod_ff, prod_in;
   logic [127:0]          acc_ff, acc_in, addend;
   logic [BASE_WIDTH-1:0] base_ff, base_in;
   logic [SUM_WIDTH-1:0]  weight_sum_ff, weight_sum_in;
   logic [SUM_WIDTH:0]    weight_total;
   logic [63:0]           opa_ff, opa_in, opb_ff, opb_in;
   logic [63:0]           t_ff, t_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [31:0]           density_ff, density_in, pressure_ff, pressure_in;
   logic                  sat_ff, sat_in, psat_ff, psat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic         inside_radius;
   logic [1:0]   pp_prev;
   logic [1:0]   pp_shift;
   logic [127:0] den_shift;
   logic         den_over;
   logic [31:0]  density_val;
   logic         pow_over;
   logic [63:0]  pow_val;
   logic         pres_over;
   logic [31:0]  pres_val;
   logic         psat_now;
   logic         need_pressure;
   logic         fin_done;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign inside_radius = (acc_ff[63:0] <= {8'b0, radius_sq_ff, 24'b0});

   assign den_shift   = acc_ff >> WF;
   assign den_over    = |den_shift[127:32];
   assign density_val = den_over ? 32'hFFFF_FFFF : den_shift[31:0];

   assign pow_over      = |acc_ff[127:96];
   assign pow_val       = pow_over ? 64'hFFFF_FFFF_FFFF_FFFF : acc_ff[95:32];
   assign pres_over     = |acc_ff[127:64];
   assign pres_val      = pres_over ? 32'hFFFF_FFFF : acc_ff[63:32];
   assign psat_now      = psat_ff | pow_over;
   assign need_pressure = (stiffness_ff != 32'd0) && (pow_val > T_ONE);

   assign weight_total = {1'b0, weight_sum_ff} + (SUM_WIDTH + 1)'(prod_ff >> WF);

   // partial product k lands at 32*(a half + b half)
   assign pp_prev  = (state_ff == ST_WIDE_LAST) ? 2'd3 : (phase_ff - 2'd1);
   assign pp_shift = {1'b0, pp_prev[1]} + {1'b0, pp_prev[0]};

   always_comb begin
      case (pp_shift)
         2'd0:    addend = {64'b0, prod_ff};
         2'd1:    addend = {32'b0, prod_ff, 32'b0};
         2'd2:    addend = {prod_ff, 64'b0};
         default: addend = '0;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_SQ_X: begin
            mul_a = mag_x_ff;
            mul_b = mag_x_ff;
         end
         ST_SQ_Y: begin
            mul_a = mag_y_ff;
            mul_b = mag_y_ff;
         end
         ST_SQ_Z: begin
            mul_a = mag_z_ff;
            mul_b = mag_z_ff;
         end
         ST_RADIUS: begin
            mul_a = acc_ff[55:24];
            mul_b = inv_radius_sq_ff;
         end
         ST_BASE_SQ: begin
            mul_a = 32'(base_ff);
            mul_b = 32'(base_ff);
         end
         ST_BASE_CUBE: begin
            mul_a = prod_ff[WF +: 32];
            mul_b = 32'(base_ff);
         end
         ST_WIDE: begin
            mul_a = phase_ff[1] ? opa_ff[63:32] : opa_ff[31:0];
            mul_b = phase_ff[0] ? opb_ff[63:32] : opb_ff[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SQ_X;
         end
         ST_SQ_X:      state_in = ST_SQ_Y;
         ST_SQ_Y:      state_in = ST_SQ_Z;
         ST_SQ_Z:      state_in = ST_SQ_SUM;
         ST_SQ_SUM:    state_in = ST_RADIUS;
         ST_RADIUS: begin
            if (inside_radius) state_in = ST_QUOT;
            else if (last_ff)  state_in = ST_LOAD;
            else               state_in = ST_IDLE;
         end
         ST_QUOT:      state_in = ST_BASE_SQ;
         ST_BASE_SQ:   state_in = ST_BASE_CUBE;
         ST_BASE_CUBE: state_in = ST_WEIGHT;
         ST_WEIGHT:    state_in = last_ff ? ST_LOAD : ST_IDLE;
         ST_LOAD:      state_in = ST_WIDE;
         ST_WIDE: begin
            if (phase_ff == 2'd3) state_in = ST_WIDE_LAST;
         end
         ST_WIDE_LAST: state_in = ST_WIDE_FIN;
         ST_WIDE_FIN:  state_in = fin_done ? ST_EMIT : ST_WIDE;
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      mag_x_in      = mag_x_ff;
      mag_y_in      = mag_y_ff;
      mag_z_in      = mag_z_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      weight_sum_in = weight_sum_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      job_in        = job_ff;
      phase_in      = phase_ff;
      t_in          = t_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      density_in    = density_ff;
      pressure_in   = pressure_ff;
      sat_in        = sat_ff;
      psat_in       = psat_ff;
      fin_done      = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_word_in   = rsp_word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_x_in = magnitude(req_word.offset_x);
               mag_y_in = magnitude(req_word.offset_y);
               mag_z_in = magnitude(req_word.offset_z);
               last_in  = req_word.last_pair;
            end
         end
         ST_SQ_Y: acc_in = {64'b0, prod_ff};
         ST_SQ_Z, ST_SQ_SUM: acc_in = acc_ff + {64'b0, prod_ff};
         ST_QUOT: begin
            // q at or above one leaves no weight
            base_in = (|prod_ff[63:40]) ? '0 : BASE_ONE - BASE_WIDTH'(prod_ff[39 -: WF]);
         end
         ST_WEIGHT: begin
            weight_sum_in = weight_total[SUM_WIDTH] ? '1 : weight_total[SUM_WIDTH-1:0];
         end
         ST_LOAD: begin
            opa_in   = {32'b0, density_scale_ff};
            opb_in   = 64'(weight_sum_ff);
            job_in   = JOB_DENSITY;
            phase_in = 2'd0;
            sat_in   = 1'b0;
            psat_in  = 1'b0;
         end
         ST_WIDE: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd0) acc_in = '0;
            else                  acc_in = acc_ff + addend;
         end
         ST_WIDE_LAST: acc_in = acc_ff + addend;
         ST_WIDE_FIN: begin
            phase_in = 2'd0;
            case (job_ff)
               JOB_DENSITY: begin
                  density_in    = density_val;
                  sat_in        = sat_ff | den_over;
                  weight_sum_in = SUM_ONE;
                  opa_in        = {32'b0, density_val};
                  opb_in        = {32'b0, inv_rest_ff};
                  job_in        = JOB_RATIO;
               end
               JOB_RATIO: begin
                  t_in   = {16'b0, acc_ff[63:16]};
                  opa_in = {16'b0, acc_ff[63:16]};
                  opb_in = {16'b0, acc_ff[63:16]};
                  job_in = JOB_T2;
               end
               JOB_T2: begin
                  t2_in   = pow_val;
                  psat_in = psat_now;
                  opa_in  = pow_val;
                  opb_in  = t_ff;
                  job_in  = JOB_T3;
               end
               JOB_T3: begin
                  t3_in   = pow_val;
                  psat_in = psat_now;
                  opa_in  = t2_ff;
                  opb_in  = t2_ff;
                  job_in  = JOB_T4;
               end
               JOB_T4: begin
                  psat_in = psat_now;
                  opa_in  = pow_val;
                  opb_in  = t3_ff;
                  job_in  = JOB_T7;
               end
               JOB_T7: begin
                  psat_in = psat_now;
                  if (!need_pressure) begin
                     pressure_in = '0;
                     fin_done    = 1'b1;
                  end else if (psat_now) begin
                     pressure_in = 32'hFFFF_FFFF;
                     sat_in      = 1'b1;
                     fin_done    = 1'b1;
                  end else begin
                     opa_in = {32'b0, stiffness_ff};
                     opb_in = pow_val - T_ONE;
                     job_in = JOB_PRESSURE;
                  end
               end
               JOB_PRESSURE: begin
                  pressure_in = pres_val;
                  sat_in      = sat_ff | pres_over;
                  fin_done    = 1'b1;
               end
               default: fin_done = 1'b1;
            endcase
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.density   = density_ff;
               rsp_word_in.pressure  = pressure_ff;
               rsp_word_in.saturated = sat_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         job_ff           <= JOB_DENSITY;
         phase_ff         <= 2'd0;
         weight_sum_ff    <= SUM_ONE;
         sat_ff           <= 1'b0;
         psat_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         radius_sq_ff     <= '0;
         inv_radius_sq_ff <= '0;
         density_scale_ff <= '0;
         inv_rest_ff      <= '0;
         stiffness_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         job_ff        <= job_in;
         phase_ff      <= phase_in;
         weight_sum_ff <= weight_sum_in;
         sat_ff        <= sat_in;
         psat_ff       <= psat_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               REG_RADIUS_SQ:        radius_sq_ff     <= csr_wdata;
               REG_INV_RADIUS_SQ:    inv_radius_sq_ff <= csr_wdata;
               REG_DENSITY_SCALE:    density_scale_ff <= csr_wdata;
               REG_INV_REST_DENSITY: inv_rest_ff      <= csr_wdata;
               REG_STIFFNESS:        stiffness_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      mag_z_ff    <= mag_z_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      t_ff        <= t_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      density_ff  <= density_in;
      pressure_ff <= pressure_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

// ===== design/sphdp_checker.sv =====
`timescale 1ns / 1ps

module sphdp_checker
   import sphdp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_word
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // the sequencer is busy right after taking a word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted word");

   // a fresh result comes only out of a busy sequencer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

   // zero density gives zero ratio and so no pressure
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.density == 32'd0) |-> (rsp_word.pressure == 32'd0))
      else $error("pressure without density");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind sph_density_pressure_top sphdp_checker u_sphdp_checker (.*);

// ===== sim/sph_density_pressure_tb_pkg.sv =====
`timescale 1ns / 1ps

package sph_density_pressure_tb_pkg;

   import sphdp_pkg::*;

   localparam int unsigned WEIGHT_FRAC = 16;
   localparam int unsigned REG_COUNT   = 5;

   localparam logic [63:0] UNIT_WEIGHT = 64'd1 << WEIGHT_FRAC;
   localparam logic [63:0] SUM_LIMIT   = (64'd1 << SUM_WIDTH) - 64'd1;
   localparam logic [63:0] RATIO_ONE   = 64'd1 << 32;
   localparam logic [63:0] RESULT_MAX  = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] WIDE_MAX    = '1;

   class density_pressure_scoreboard;
      logic [31:0]  radius_sq;
      logic [31:0]  inv_radius_sq;
      logic [31:0]  scale;
      logic [31:0]  inv_rest;
      logic [31:0]  stiffness;
      logic [63:0]  weight_sum;
      rsp_word_type particle_results[$];
      int unsigned  errors;

      function new();
         radius_sq     = '0;
         inv_radius_sq = '0;
         scale         = '0;
         inv_rest      = '0;
         stiffness     = '0;
         weight_sum    = UNIT_WEIGHT;
         errors        = 0;
      endfunction

      function void write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                              input logic [31:0] value);
         case (index)
            REG_RADIUS_SQ:        radius_sq = value;
            REG_INV_RADIUS_SQ:    inv_radius_sq = value;
            REG_DENSITY_SCALE:    scale = value;
            REG_INV_REST_DENSITY: inv_rest = value;
            REG_STIFFNESS:        stiffness = value;
            default: ;
         endcase
      endfunction

      function logic [31:0] magnitude(input logic [31:0] value);
         return value[31] ? ~value + 32'd1 : value;
      endfunction

      // (a * b) >> shift, pinned to limit when it does not fit
      function logic [63:0] clamp_product(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned shift,
                                          input logic [63:0] limit, inout bit clipped);
         logic [127:0] scaled;
         scaled = (128'(a) * 128'(b)) >> shift;
         if (scaled > 128'(limit)) begin
            clipped = 1'b1;
            return limit;
         end
         return scaled[63:0];
      endfunction

      function void note_pair(input req_word_type pair);
         logic [31:0]  ax, ay, az;
         logic [63:0]  r2_full, r2, q, base, w;
         logic [63:0]  density, pressure, t, t2, t3, t4, t7;
         bit           clipped, power_clipped;
         rsp_word_type result;

         ax = magnitude(pair.offset_x);
         ay = magnitude(pair.offset_y);
         az = magnitude(pair.offset_z);
         r2_full = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);
         if (r2_full <= (64'(radius_sq) << 24)) begin
            r2 = r2_full >> 24;
            q = (r2 * 64'(inv_radius_sq)) >> (40 - WEIGHT_FRAC);
            base = (q >= UNIT_WEIGHT) ? 64'd0 : UNIT_WEIGHT - q;
            w = (((base * base) >> WEIGHT_FRAC) * base) >> WEIGHT_FRAC;
            weight_sum = weight_sum + w;
            if (weight_sum > SUM_LIMIT) weight_sum = SUM_LIMIT;
         end
         if (!pair.last_pair) return;

         clipped = 1'b0;
         power_clipped = 1'b0;
         density = clamp_product(64'(scale), weight_sum, WEIGHT_FRAC, RESULT_MAX, clipped);
         t  = (density * 64'(inv_rest)) >> 16;
         t2 = clamp_product(t, t, 32, WIDE_MAX, power_clipped);
         t3 = clamp_product(t2, t, 32, WIDE_MAX, power_clipped);
         t4 = clamp_product(t2, t2, 32, WIDE_MAX, power_clipped);
         t7 = clamp_product(t4, t3, 32, WIDE_MAX, power_clipped);
         if (stiffness == '0 || t7 <= RATIO_ONE) begin
            pressure = '0;
         end else if (power_clipped) begin
            pressure = RESULT_MAX;
            clipped = 1'b1;
         end else begin
            pressure = clamp_product(64'(stiffness), t7 - RATIO_ONE, 32, RESULT_MAX, clipped);
         end

         result.density   = density[31:0];
         result.pressure  = pressure[31:0];
         result.saturated = clipped;
         particle_results.push_back(result);
         weight_sum = UNIT_WEIGHT;
      endfunction

      function int unsigned outstanding();
         return particle_results.size();
      endfunction

      function void check_word(input rsp_word_type got);
         rsp_word_type want;
         if (particle_results.size() == 0) begin
            $error("result word with no particle pending: density %h pressure %h saturated %b",
                   got.density, got.pressure, got.saturated);
            errors++;
            return;
         end
         want = particle_results.pop_front();
         if (got.density !== want.density) begin
            $error("density: expected %h, got %h", want.density, got.density);
            errors++;
         end
         if (got.pressure !== want.pressure) begin
            $error("pressure: expected %h, got %h", want.pressure, got.pressure);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $error("saturated: expected %b, got %b", want.saturated, got.saturated);
            errors++;
         end
      endfunction
   endclass

endpackage

// ===== sim/tb_sph_density_pressure_top.sv =====
`timescale 1ns / 1ps

module tb_sph_density_pressure_top;

   import sphdp_pkg::*;
   import sph_density_pressure_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned TAIL_CYCLES   = 128;
   localparam int unsigned PHASE_PAIRS   = 155;
   localparam int unsigned INDEX_TOP     = (1 << CSR_INDEX_WIDTH) - 1;
   localparam logic [31:0] HALF_METER    = 32'h0080_0000;
   localparam logic [31:0] INV_REST_1500 = 32'd2863311;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_word_type               req_word = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_word_type               rsp_word;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0]       csr_wdata = '0;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned cycle_count = 0;
   logic [31:0] reach = HALF_METER;

   density_pressure_scoreboard sb;

   sph_density_pressure_top #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_word);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sph_density_pressure_top regression: fail");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic load_config(input logic [31:0] radius_sq, input logic [31:0] inv_radius_sq,
                              input logic [31:0] scale, input logic [31:0] inv_rest,
                              input logic [31:0] stiffness);
      logic [CSR_INDEX_WIDTH-1:0] stray;
      write_csr(REG_RADIUS_SQ, radius_sq);
      write_csr(REG_INV_RADIUS_SQ, inv_radius_sq);
      write_csr(REG_DENSITY_SCALE, scale);
      write_csr(REG_INV_REST_DENSITY, inv_rest);
      write_csr(REG_STIFFNESS, stiffness);
      // an index past the register file must leave everything alone
      if ($urandom_range(1) == 1) begin
         stray = CSR_INDEX_WIDTH'($urandom_range(INDEX_TOP, REG_COUNT));
         write_csr(stray, $urandom);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_pair(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                            input logic last);
      req_word_type pair;
      pair.offset_x  = x;
      pair.offset_y  = y;
      pair.offset_z  = z;
      pair.last_pair = last;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= pair;
      do @(posedge clock); while (!req_ready);
      sb.note_pair(pair);
   endtask

   // drop valid, wait out every pending particle, then let the sequencer finish
   task automatic settle(input int unsigned tail);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_offset(input int unsigned span);
      logic [31:0] mag;
      mag = $urandom_range(span);
      return ($urandom_range(1) == 1) ? ~mag + 32'd1 : mag;
   endfunction

   function automatic logic [31:0] maybe_extreme(input logic [31:0] value);
      case ($urandom_range(11))
         0: return '0;
         1: return '1;
         default: return value;
      endcase
   endfunction

   task automatic random_config();
      logic [63:0] radius_sq, inv_radius_sq;
      logic [31:0] rest, scale, inv_rest;
      reach = $urandom_range(32'h0400_0000, 32'h0004_0000);
      radius_sq = (64'(reach) * 64'(reach)) >> 24;
      inv_radius_sq = (64'd1 << 40) / radius_sq;
      // nudge 1/h^2 up so pairs near the rim round past one
      if ($urandom_range(3) == 0) inv_radius_sq += $urandom_range(3);
      rest = $urandom_range(2000, 1);
      inv_rest = (rest == 1) ? 32'hFFFF_FFFF : 32'((64'd1 << 32) / rest);
      // aim the density near rest so the ratio lands on both sides of one: zero and nonzero pressure
      scale = rest * $urandom_range(37000, 18000);
      load_config(maybe_extreme(radius_sq[31:0]), maybe_extreme(inv_radius_sq[31:0]),
                  maybe_extreme(scale), maybe_extreme(inv_rest),
                  maybe_extreme($urandom_range(32'h0100_0000)));
   endtask

   task automatic run_phase(input int unsigned budget);
      int unsigned sent, count, i, roll, span;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 12) begin
            send_pair($urandom, $urandom, $urandom, 1'($urandom_range(1)));
            sent++;
         end else begin
            count = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            for (i = 1; i <= count; i++) begin
               roll = $urandom_range(99);
               if (roll >= 95) begin
                  send_pair($urandom, $urandom, $urandom, i == count);
               end else begin
                  span = (roll < 70) ? reach >> 1 : reach;
                  send_pair(pick_offset(span), pick_offset(span), pick_offset(span), i == count);
               end
            end
            sent += count;
         end
      end
   endtask

   initial begin
      int unsigned stage, phase;
      sb = new();
      sender_idle_pct   = 18;
      receiver_idle_pct = 64;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: only a zero offset lies inside the radius
      send_pair('0, '0, '0, 1'b1);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

      settle(SETTLE_CYCLES);
      load_config(32'h0040_0000, 32'h0004_0000, 32'h03E8_0000, INV_REST_1500, 32'h00C8_0000);
      send_pair('0, '0, '0, 1'b0);
      send_pair(HALF_METER, '0, '0, 1'b0);
      send_pair('0, ~HALF_METER, '0, 1'b0);
      send_pair(32'h0040_0000, 32'hFFC0_0000, 32'h0020_0000, 1'b0);
      send_pair(32'hFFE0_0000, '0, 32'h8000_0000, 1'b0);
      send_pair('0, '0, 32'h0010_0000, 1'b1);
      send_pair(32'h7FFF_FFFF, '0, '0, 1'b1);

      // q lands just above one on the rim; zero stiffness with density over rest
      settle(SETTLE_CYCLES);
      load_config(32'h0040_0000, 32'h0004_0004, 32'h03E8_0000, INV_REST_1500, '0);
      send_pair(HALF_METER, '0, '0, 1'b0);
      send_pair('0, '0, 32'hFF80_0000, 1'b0);
      send_pair('0, '0, '0, 1'b0);
      send_pair(32'd1, 32'd1, 32'd1, 1'b1);

      settle(SETTLE_CYCLES);
      load_config('1, '1, '1, '1, '1);
      send_pair('0, '0, '0, 1'b1);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_pair(32'h0FFF_FFFF, '0, '0, 1'b1);

      // ratio exactly one, then pressure overflow without power overflow
      settle(SETTLE_CYCLES);
      load_config(32'h0040_0000, 32'h0004_0000, 32'h0001_0000, 32'h8000_0000, '1);
      send_pair('0, '0, '0, 1'b1);
      send_pair('0, '0, '0, 1'b0);
      send_pair('0, '0, '0, 1'b1);

      // seventh power overflows, with and without stiffness
      settle(SETTLE_CYCLES);
      load_config(32'h0040_0000, 32'h0004_0000, 32'h0040_0000, '1, 32'h0000_0001);
      send_pair(32'h7FFF_FFFF, '0, '0, 1'b1);
      settle(SETTLE_CYCLES);
      load_config(32'h0040_0000, 32'h0004_0000, 32'h0040_0000, '1, '0);
      send_pair('0, 32'h8000_0000, '0, 1'b1);

      for (stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               sender_idle_pct   = 18;
               receiver_idle_pct = 64;
            end
            1: begin
               sender_idle_pct   = 64;
               receiver_idle_pct = 18;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (phase = 0; phase < 3; phase++) begin
            settle(SETTLE_CYCLES);
            random_config();
            run_phase(PHASE_PAIRS);
         end
      end

      settle(TAIL_CYCLES);
      if (sb.errors == 0) begin
         $display("sph_density_pressure_top regression: pass");
      end else begin
         $display("sph_density_pressure_top regression: fail");
      end
      $finish;
   end

endmodule
